### sv/ldps_pkg.sv
`default_nettype none

package ldps_pkg;

	// Fixed field widths of the request and result channels
	localparam int LIMIT_W = 11;
	localparam int OUT_W   = 10;

	// First divisor searched
	localparam int FIRST_DIVISOR = 2;

	// Remainder reduction: r*10 < 16*d, so four restoring passes (8d, 4d, 2d, d)
	localparam int MOD_PASSES = 4;
	localparam int SHIFT_W    = $clog2(MOD_PASSES);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_NEXT_DIV,
		S_READ,
		S_CHECK,
		S_MOD,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

### sv/ldps_if.sv
`default_nettype none

// Request channel: one search limit per request
interface ldps_in_if;
	import ldps_pkg::*;

	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] limit;

	modport source (output valid, output limit, input ready);
	modport sink   (input valid, input limit, output ready);
endinterface

// Result channel: best divisor and its period
interface ldps_out_if;
	import ldps_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] best_divisor;
	logic [OUT_W-1:0] best_period;

	modport source (output valid, output best_divisor, output best_period, input ready);
	modport sink   (input valid, input best_divisor, input best_period, output ready);
endinterface

`default_nettype wire

### sv/ldps_table.sv
`default_nettype none

// Single-port remainder table: one write or one registered read per cycle
module ldps_table #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 21
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### sv/ldps_csub.sv
`default_nettype none

// Shared compare-subtract: one restoring pass of acc mod (divisor << shift)
module ldps_csub #(
	parameter int ACC_W = 14,
	parameter int D_W   = 10
) (
	input  wire logic [ACC_W-1:0]            acc,
	input  wire logic [D_W-1:0]              divisor,
	input  wire logic [ldps_pkg::SHIFT_W-1:0] shift,
	output logic      [ACC_W-1:0]            res
);
	import ldps_pkg::*;

	logic [ACC_W-1:0] dshift;

	always_comb begin
		dshift = ACC_W'(divisor) << shift;
		res    = (acc >= dshift) ? (acc - dshift) : acc;
	end

endmodule

`default_nettype wire

### sv/longest_decimal_period_search.sv
`default_nettype none

// Searches every divisor d with 2 <= d < limit (limit saturated to MAX_DIVISOR) for the
// longest repeating period of 1/d in decimal and returns that divisor and its period; a
// terminating expansion counts as period 0 and ties go to the larger divisor, so a search in
// which nothing repeats returns the largest divisor, and a limit of two or less returns zeros.
// One request at a time. Each divisor has a setup step, then for each remainder visited a
// table read, a check and four passes of the shared compare-subtract unit that forms
// r*10 mod d, and a closing step.
// The remainder table is tagged with a per-divisor epoch instead of being cleared each time;
// a clearing pass over all MAX_DIVISOR entries runs after reset and whenever the epoch wraps, and no
// request is taken during it. A finished result waits in an output register.
module longest_decimal_period_search #(
	parameter int MAX_DIVISOR = 1024
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ldps_in_if.sink     in_ch,
	ldps_out_if.source  out_ch
);
	import ldps_pkg::*;

	localparam int ADDR_W = $clog2(MAX_DIVISOR);
	localparam int DIV_W  = $clog2(MAX_DIVISOR + 1);
	localparam int POS_W  = ADDR_W;
	localparam int TAG_W  = DIV_W;
	localparam int ENT_W  = TAG_W + POS_W;
	localparam int ACC_W  = ADDR_W + 4;
	localparam int LIM_W  = (DIV_W > LIMIT_W) ? DIV_W : LIMIT_W;

	state_t state_q, state_d;

	logic                busy_q;
	logic [TAG_W-1:0]    epoch_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [DIV_W-1:0]    lim_q;
	logic [DIV_W-1:0]    d_q;
	logic [DIV_W-1:0]    best_div_q;
	logic [POS_W-1:0]    best_per_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_div_q;
	logic [OUT_W-1:0]    out_per_q;
	logic [SHIFT_W-1:0]  k_q;
	logic [ADDR_W-1:0]   r_q;
	logic [POS_W-1:0]    pos_q;
	logic [ACC_W-1:0]    acc_q;

	logic                in_acc;
	logic                clr_last;
	logic                div_more;
	logic                epoch_full;
	logic                r_zero;
	logic                hit;
	logic                can_load;
	logic                div_done;
	logic [POS_W-1:0]    cand;
	logic [LIM_W-1:0]    lim_ext;
	logic [LIM_W-1:0]    lim_sat;

	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_addr;
	logic [ENT_W-1:0]    mem_wdata;
	logic [ENT_W-1:0]    mem_rdata;
	logic [TAG_W-1:0]    rd_tag;
	logic [POS_W-1:0]    rd_pos;
	logic [ACC_W-1:0]    csub_res;

	// Remainder table: {epoch tag, first position}
	ldps_table #(
		.DEPTH (MAX_DIVISOR),
		.DATA_W(ENT_W)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Shared reduction unit
	ldps_csub #(
		.ACC_W(ACC_W),
		.D_W  (ADDR_W)
	) u_csub (
		.acc    (acc_q),
		.divisor(d_q[ADDR_W-1:0]),
		.shift  (k_q),
		.res    (csub_res)
	);

	// Status decode
	always_comb begin
		in_acc     = in_ch.valid && in_ch.ready;
		clr_last   = (clr_q == ADDR_W'(MAX_DIVISOR - 1));
		div_more   = (d_q < lim_q);
		epoch_full = &epoch_q;
		r_zero     = (r_q == '0);
		rd_tag     = mem_rdata[ENT_W-1:POS_W];
		rd_pos     = mem_rdata[POS_W-1:0];
		hit        = (rd_tag == epoch_q);
		can_load   = !out_valid_q || out_ch.ready;
		cand       = r_zero ? '0 : (pos_q - rd_pos);
		lim_ext    = LIM_W'(in_ch.limit);
		lim_sat    = (lim_ext > LIM_W'(MAX_DIVISOR)) ? LIM_W'(MAX_DIVISOR) : lim_ext;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = busy_q ? S_NEXT_DIV : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_NEXT_DIV;
				end
			end
			S_NEXT_DIV: begin
				if (!div_more) begin
					state_d = S_FINISH;
				end else if (epoch_full) begin
					state_d = S_CLEAR;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = r_zero ? S_NEXT_DIV : S_CHECK;
			end
			S_CHECK: begin
				state_d = hit ? S_NEXT_DIV : S_MOD;
			end
			S_MOD: begin
				if (k_q == '0) begin
					state_d = S_READ;
				end
			end
			S_FINISH: begin
				if (can_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ch.ready = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = r_q;
		mem_wdata   = {epoch_q, pos_q};
		div_done    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_IDLE:  in_ch.ready = 1'b1;
			S_READ: begin
				mem_re   = !r_zero;
				div_done = r_zero;
			end
			S_CHECK: begin
				mem_we   = !hit;
				div_done = hit;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			busy_q      <= 1'b0;
			epoch_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;

			// clearing sweep; epoch restarts once the table is clean
			if (state_q == S_CLEAR) begin
				clr_q <= clr_last ? '0 : (clr_q + 1'b1);
				if (clr_last) begin
					epoch_q <= '0;
				end
			end

			if (in_acc) begin
				busy_q <= 1'b1;
			end

			if (state_q == S_NEXT_DIV && div_more && !epoch_full) begin
				epoch_q <= epoch_q + 1'b1;
			end

			if (state_q == S_CHECK && !hit) begin
				k_q <= SHIFT_W'(MOD_PASSES - 1);
			end else if (state_q == S_MOD) begin
				k_q <= k_q - 1'b1;
			end

			// result register
			if (state_q == S_FINISH && can_load) begin
				out_valid_q <= 1'b1;
				busy_q      <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lim_q      <= DIV_W'(lim_sat);
			d_q        <= DIV_W'(FIRST_DIVISOR);
			best_div_q <= '0;
			best_per_q <= '0;
		end

		// start of a divisor: remainder of 1/d is 1
		if (state_q == S_NEXT_DIV && div_more && !epoch_full) begin
			r_q   <= ADDR_W'(1);
			pos_q <= '0;
		end

		// divisor closed: keep the best, ties to the larger divisor
		if (div_done) begin
			if (cand >= best_per_q) begin
				best_per_q <= cand;
				best_div_q <= d_q;
			end
			d_q <= d_q + 1'b1;
		end

		// new remainder: record it and form r*10
		if (state_q == S_CHECK && !hit) begin
			acc_q <= (ACC_W'(r_q) << 3) + (ACC_W'(r_q) << 1);
			pos_q <= pos_q + 1'b1;
		end

		if (state_q == S_MOD) begin
			acc_q <= csub_res;
			if (k_q == '0) begin
				r_q <= csub_res[ADDR_W-1:0];
			end
		end

		if (state_q == S_FINISH && can_load) begin
			out_div_q <= OUT_W'(best_div_q);
			out_per_q <= OUT_W'(best_per_q);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.best_divisor = out_div_q;
	assign out_ch.best_period  = out_per_q;

endmodule

`default_nettype wire
